[rtl/core/bbt_pkg.sv]
`timescale 1ns / 1ps

package bbt_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int DIM        = 4;
    localparam int NUM_LANES  = 4;
    localparam int NUM_ENTRY  = DIM * NUM_LANES;
    localparam int INDEX_BITS = $clog2(NUM_ENTRY);

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_BOX  = 1'b1;

    typedef struct packed {
        logic mul_en;
        logic prod_en;
        logic pair_en;
        logic out_en;
    } pipe_ctrl_t;

endpackage

[rtl/core/bbt_matrix.sv]
`timescale 1ns / 1ps

module bbt_matrix import bbt_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [INDEX_BITS-1:0] wr_index,
    input  logic [DATA_WIDTH-1:0] wr_value,
    output logic [DATA_WIDTH-1:0] entries [NUM_ENTRY]
);

    logic [DATA_WIDTH-1:0] entry_reg [NUM_ENTRY];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_ENTRY; i++) begin
                entry_reg[i] <= '0;
            end
        end else if (wr_en) begin
            entry_reg[wr_index] <= wr_value;
        end
    end

    assign entries = entry_reg;

endmodule

[rtl/core/bbt_lane.sv]
`timescale 1ns / 1ps

module bbt_lane import bbt_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                     aclk,
    input  pipe_ctrl_t                               ctrl,
    input  logic signed [DATA_WIDTH-1:0]             lo_corner [DIM],
    input  logic signed [DATA_WIDTH-1:0]             hi_corner [DIM],
    input  logic signed [DATA_WIDTH-1:0]             coef      [DIM],
    output logic signed [2*DATA_WIDTH-FRAC_BITS:0]   min_pair_a,
    output logic signed [2*DATA_WIDTH-FRAC_BITS:0]   min_pair_b,
    output logic signed [2*DATA_WIDTH-FRAC_BITS:0]   max_pair_a,
    output logic signed [2*DATA_WIDTH-FRAC_BITS:0]   max_pair_b
);

    localparam int HB  = DATA_WIDTH / 2;
    localparam int LB  = DATA_WIDTH - HB;
    localparam int PW  = 2 * DATA_WIDTH;
    localparam int SHW = PW - FRAC_BITS;
    localparam int PRW = SHW + 1;

    logic signed [SHW-1:0] prod_min_reg [DIM];
    logic signed [SHW-1:0] prod_max_reg [DIM];
    logic signed [PRW-1:0] min_a_reg, min_b_reg, max_a_reg, max_b_reg;

    for (genvar r = 0; r < DIM; r++) begin : g_row
        logic                           pos;
        logic signed [DATA_WIDTH-1:0]   op_min, op_max;
        logic signed [HB-1:0]           coef_hi;
        logic signed [LB:0]             coef_lo;
        logic signed [DATA_WIDTH+HB-1:0] pmin_hi_reg, pmax_hi_reg;
        logic signed [DATA_WIDTH+LB:0]  pmin_lo_reg, pmax_lo_reg;
        logic signed [PW-1:0]           full_min, full_max;

        // positive entry keeps corners, zero or negative swaps them
        assign pos     = !coef[r][DATA_WIDTH-1] && (coef[r] != '0);
        assign op_min  = pos ? lo_corner[r] : hi_corner[r];
        assign op_max  = pos ? hi_corner[r] : lo_corner[r];
        assign coef_hi = coef[r][DATA_WIDTH-1:LB];
        assign coef_lo = {1'b0, coef[r][LB-1:0]};

        always_ff @(posedge aclk) begin
            if (ctrl.mul_en) begin
                pmin_hi_reg <= op_min * coef_hi;
                pmin_lo_reg <= op_min * coef_lo;
                pmax_hi_reg <= op_max * coef_hi;
                pmax_lo_reg <= op_max * coef_lo;
            end
        end

        assign full_min = (PW'(pmin_hi_reg) <<< LB) + PW'(pmin_lo_reg);
        assign full_max = (PW'(pmax_hi_reg) <<< LB) + PW'(pmax_lo_reg);

        // floor shift by dropping fraction bits
        always_ff @(posedge aclk) begin
            if (ctrl.prod_en) begin
                prod_min_reg[r] <= full_min[PW-1:FRAC_BITS];
                prod_max_reg[r] <= full_max[PW-1:FRAC_BITS];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.pair_en) begin
            min_a_reg <= PRW'(prod_min_reg[0]) + PRW'(prod_min_reg[1]);
            min_b_reg <= PRW'(prod_min_reg[2]) + PRW'(prod_min_reg[3]);
            max_a_reg <= PRW'(prod_max_reg[0]) + PRW'(prod_max_reg[1]);
            max_b_reg <= PRW'(prod_max_reg[2]) + PRW'(prod_max_reg[3]);
        end
    end

    assign min_pair_a = min_a_reg;
    assign min_pair_b = min_b_reg;
    assign max_pair_a = max_a_reg;
    assign max_pair_b = max_b_reg;

endmodule

[rtl/core/bbt_merge.sv]
`timescale 1ns / 1ps

module bbt_merge import bbt_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  pipe_ctrl_t                             ctrl,
    input  logic signed [2*DATA_WIDTH-FRAC_BITS:0] min_pair_a [NUM_LANES],
    input  logic signed [2*DATA_WIDTH-FRAC_BITS:0] min_pair_b [NUM_LANES],
    input  logic signed [2*DATA_WIDTH-FRAC_BITS:0] max_pair_a [NUM_LANES],
    input  logic signed [2*DATA_WIDTH-FRAC_BITS:0] max_pair_b [NUM_LANES],
    output logic        [DATA_WIDTH-1:0]           result     [2*NUM_LANES]
);

    localparam int PRW = 2 * DATA_WIDTH - FRAC_BITS + 1;
    localparam int TW  = PRW + 1;

    logic [DATA_WIDTH-1:0] res_reg [2*NUM_LANES];

    function automatic logic [DATA_WIDTH-1:0] sat(input logic signed [TW-1:0] v);
        logic [TW-DATA_WIDTH:0] top;
        top = v[TW-1:DATA_WIDTH-1];
        if (top == '0 || top == '1) begin
            return v[DATA_WIDTH-1:0];
        end else if (v[TW-1]) begin
            return {1'b1, {(DATA_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end
    endfunction

    for (genvar c = 0; c < NUM_LANES; c++) begin : g_col
        logic signed [TW-1:0] total_min, total_max;

        assign total_min = TW'(min_pair_a[c]) + TW'(min_pair_b[c]);
        assign total_max = TW'(max_pair_a[c]) + TW'(max_pair_b[c]);

        always_ff @(posedge aclk) begin
            if (ctrl.out_en) begin
                res_reg[c]             <= sat(total_min);
                res_reg[NUM_LANES + c] <= sat(total_max);
            end
        end
    end

    assign result = res_reg;

endmodule

[rtl/core/bounding_box_transform_core.sv]
`timescale 1ns / 1ps

// channel   ports             tdata (low bit up)                             tuser
// s_axis    tvalid/tready     entry_index, entry_value, min_x..min_w,        action
//                             max_x..max_w, zero pad to bytes
// m_axis    tvalid/tready     out_min_x..out_min_w, out_max_x..out_max_w     -
//
// one request per cycle while the pipeline is not held by m_axis stalls; a box result passes the stages
// (multiply, product shift, pair sums, final sum with saturation into the output register)
// load requests write the matrix at once and produce no result
// aresetn clears the matrix to zero and empties the pipeline
// each stage holds only while it is full and the next cannot accept, so bubbles close up under m_axis stalls

module bounding_box_transform_core import bbt_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // entry_index, entry_value, min_x, min_y, min_z, min_w, max_x, max_y, max_z, max_w
    input  logic [((INDEX_BITS+9*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // action
    input  logic [0:0]                                s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // out_min_x, out_min_y, out_min_z, out_min_w, out_max_x, out_max_y, out_max_z, out_max_w
    output logic [((2*NUM_LANES*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

    localparam int VAL_LSB = INDEX_BITS;
    localparam int MIN_LSB = VAL_LSB + DATA_WIDTH;
    localparam int MAX_LSB = MIN_LSB + DIM * DATA_WIDTH;
    localparam int PRW     = 2 * DATA_WIDTH - FRAC_BITS + 1;
    localparam int OUT_W   = 2 * NUM_LANES * DATA_WIDTH;
    localparam int M_TW    = ((OUT_W + 7) / 8) * 8;

    logic                         in_fire;
    logic                         mul_v_reg, prod_v_reg, pair_v_reg, out_v_reg;
    logic                         rdy_mul, rdy_prod, rdy_pair, rdy_out;
    pipe_ctrl_t                   ctrl;
    logic [DATA_WIDTH-1:0]        entries    [NUM_ENTRY];
    logic signed [DATA_WIDTH-1:0] lo_corner  [DIM];
    logic signed [DATA_WIDTH-1:0] hi_corner  [DIM];
    logic signed [DATA_WIDTH-1:0] lane_coef  [NUM_LANES][DIM];
    logic signed [PRW-1:0]        min_pair_a [NUM_LANES];
    logic signed [PRW-1:0]        min_pair_b [NUM_LANES];
    logic signed [PRW-1:0]        max_pair_a [NUM_LANES];
    logic signed [PRW-1:0]        max_pair_b [NUM_LANES];
    logic [DATA_WIDTH-1:0]        result     [2*NUM_LANES];
    logic [OUT_W-1:0]             out_flat;

    assign rdy_out  = !out_v_reg  || m_axis_tready;
    assign rdy_pair = !pair_v_reg || rdy_out;
    assign rdy_prod = !prod_v_reg || rdy_pair;
    assign rdy_mul  = !mul_v_reg  || rdy_prod;

    assign s_axis_tready = rdy_mul;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign ctrl.mul_en  = rdy_mul;
    assign ctrl.prod_en = rdy_prod;
    assign ctrl.pair_en = rdy_pair;
    assign ctrl.out_en  = rdy_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_v_reg  <= 1'b0;
            prod_v_reg <= 1'b0;
            pair_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            if (rdy_mul) begin
                mul_v_reg <= in_fire && (s_axis_tuser[0] == ACT_BOX);
            end
            if (rdy_prod) begin
                prod_v_reg <= mul_v_reg;
            end
            if (rdy_pair) begin
                pair_v_reg <= prod_v_reg;
            end
            if (rdy_out) begin
                out_v_reg <= pair_v_reg;
            end
        end
    end

    bbt_matrix #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_matrix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (in_fire && (s_axis_tuser[0] == ACT_LOAD)),
        .wr_index (s_axis_tdata[INDEX_BITS-1:0]),
        .wr_value (s_axis_tdata[VAL_LSB +: DATA_WIDTH]),
        .entries  (entries)
    );

    for (genvar r = 0; r < DIM; r++) begin : g_corner
        assign lo_corner[r] = s_axis_tdata[MIN_LSB + r*DATA_WIDTH +: DATA_WIDTH];
        assign hi_corner[r] = s_axis_tdata[MAX_LSB + r*DATA_WIDTH +: DATA_WIDTH];
    end

    for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
        for (genvar r = 0; r < DIM; r++) begin : g_coef
            assign lane_coef[c][r] = entries[r*NUM_LANES + c];
        end

        bbt_lane #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .lo_corner  (lo_corner),
            .hi_corner  (hi_corner),
            .coef       (lane_coef[c]),
            .min_pair_a (min_pair_a[c]),
            .min_pair_b (min_pair_b[c]),
            .max_pair_a (max_pair_a[c]),
            .max_pair_b (max_pair_b[c])
        );
    end

    bbt_merge #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_merge (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .min_pair_a (min_pair_a),
        .min_pair_b (min_pair_b),
        .max_pair_a (max_pair_a),
        .max_pair_b (max_pair_b),
        .result     (result)
    );

    for (genvar k = 0; k < 2*NUM_LANES; k++) begin : g_pack
        assign out_flat[k*DATA_WIDTH +: DATA_WIDTH] = result[k];
    end

    assign m_axis_tdata  = M_TW'(out_flat);
    assign m_axis_tvalid = out_v_reg;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import bbt_pkg::*;

    localparam int DW               = DATA_WIDTH_DEF;
    localparam int FB               = FRAC_BITS_DEF;
    localparam int IN_BITS          = ((INDEX_BITS + 9 * DW + 7) / 8) * 8;
    localparam int OUT_BITS         = ((2 * NUM_LANES * DW + 7) / 8) * 8;
    localparam int DIRECTED_ROWS    = 23;
    localparam int RANDOM_PER_PHASE = 500;
    localparam int HOLD_CYCLES      = 300;
    localparam int STALL_LIMIT      = 5000;
    localparam int DRAIN_CYCLES     = 12;
    localparam int MAX_REPORTS      = 10;

    localparam logic [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] Q_ONE = 1 << FB;

    typedef logic [DIM-1:0][DW-1:0] corner_t;

    // lo sits in the low half, matching m_axis_tdata
    typedef struct packed {
        corner_t hi;
        corner_t lo;
    } box_t;

    typedef struct packed {
        logic                  action;
        box_t                  box;
        logic [DW-1:0]         value;
        logic [INDEX_BITS-1:0] index;
    } request_t;

    typedef struct packed {
        request_t req;
        logic     typed;
        box_t     want;
    } vector_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata  = '0;
    logic [0:0]          s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] m_axis_tdata;

    logic [DW-1:0] coeff_store [NUM_ENTRY];
    box_t          expected_boxes [$];
    vector_t       directed_table [DIRECTED_ROWS];
    int unsigned   mismatch_count = 0;
    int unsigned   quiet_cycles   = 0;
    int unsigned   send_gap_pct   = 0;
    int unsigned   recv_stall_pct = 0;
    int unsigned   hold_left      = 0;
    logic          hold_go        = 1'b0;
    logic          hold_taken     = 1'b0;
    string         lane_tag       = "xyzw";

    bounding_box_transform_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic signed [2*DW-1:0] scaled_product(logic signed [DW-1:0] a,
                                                              logic signed [DW-1:0] m);
        logic signed [2*DW-1:0] p;
        p = a * m;
        return p >>> FB;
    endfunction

    function automatic logic [DW-1:0] clamp_q(logic signed [2*DW-1:0] s);
        logic [DW:0] top;
        top = s[2*DW-1:DW-1];
        if (top == '0 || top == '1) return s[DW-1:0];
        return s[2*DW-1] ? Q_MIN : Q_MAX;
    endfunction

    // positive entry: min corner feeds min sum; zero or negative: corners swap
    function automatic box_t transform_box(box_t b);
        box_t                   res;
        logic signed [2*DW-1:0] lo_sum;
        logic signed [2*DW-1:0] hi_sum;
        logic signed [DW-1:0]   m;
        logic                   pos;
        for (int col = 0; col < NUM_LANES; col++) begin
            lo_sum = '0;
            hi_sum = '0;
            for (int row = 0; row < DIM; row++) begin
                m = coeff_store[row * NUM_LANES + col];
                pos = (m > 0);
                lo_sum += scaled_product(pos ? b.lo[row] : b.hi[row], m);
                hi_sum += scaled_product(pos ? b.hi[row] : b.lo[row], m);
            end
            res.lo[col] = clamp_q(lo_sum);
            res.hi[col] = clamp_q(hi_sum);
        end
        return res;
    endfunction

    function automatic logic [DW-1:0] pick_q(int unsigned span);
        logic [DW-1:0] v;
        case ($urandom_range(15))
            0: v = Q_MIN;
            1: v = Q_MAX;
            2: v = '0;
            3: v = Q_ONE;
            4: v = -Q_ONE;
            5: v = $urandom;
            default: begin
                v = $urandom_range((1 << span) - 1);
                if ($urandom_range(1) == 1) v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic request_t random_request();
        request_t      r;
        logic [DW-1:0] t;
        r.action = ($urandom_range(3) == 0) ? ACT_LOAD : ACT_BOX;
        r.index  = INDEX_BITS'($urandom_range(NUM_ENTRY - 1));
        r.value  = pick_q(18);
        for (int k = 0; k < DIM; k++) begin
            r.box.lo[k] = pick_q(24);
            r.box.hi[k] = pick_q(24);
            // mostly well-ordered boxes, some inverted
            if ($urandom_range(4) != 0 && $signed(r.box.lo[k]) > $signed(r.box.hi[k])) begin
                t = r.box.lo[k];
                r.box.lo[k] = r.box.hi[k];
                r.box.hi[k] = t;
            end
        end
        return r;
    endfunction

    function automatic vector_t load_row(int unsigned idx, logic [DW-1:0] val);
        vector_t v;
        v.req.action = ACT_LOAD;
        v.req.index  = INDEX_BITS'(idx);
        v.req.value  = val;
        v.req.box    = '1;
        v.typed      = 1'b0;
        v.want       = '0;
        return v;
    endfunction

    function automatic vector_t box_row(corner_t lo, corner_t hi, logic typed, box_t want);
        vector_t v;
        v.req.action = ACT_BOX;
        v.req.index  = '1;
        v.req.value  = '1;
        v.req.box.lo = lo;
        v.req.box.hi = hi;
        v.typed      = typed;
        v.want       = want;
        return v;
    endfunction

    task automatic send_request(request_t r, logic typed, box_t want);
        while ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_BITS'({r.box, r.value, r.index});
        s_axis_tuser  <= r.action;
        do @(posedge aclk); while (!s_axis_tready);
        if (r.action == ACT_LOAD) coeff_store[r.index] = r.value;
        else expected_boxes.push_back(typed ? want : transform_box(r.box));
    endtask

    task automatic check_field(string name, int k, logic [DW-1:0] want, logic [DW-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%s_%c mismatch: expected %h, got %h", name, lane_tag[k], want, got);
        end
    endtask

    always @(posedge aclk) begin
        box_t got;
        box_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = box_t'(m_axis_tdata);
            if (expected_boxes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: got %h", got);
            end else begin
                want = expected_boxes.pop_front();
                for (int k = 0; k < DIM; k++) begin
                    check_field("out_min", k, want.lo[k], got.lo[k]);
                    check_field("out_max", k, want.hi[k], got.hi[k]);
                end
            end
        end
    end

    // receiver side, with one long hold-off
    always @(posedge aclk) begin
        if (hold_go && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        corner_t all_min;
        corner_t all_max;
        corner_t edge_lo;
        corner_t edge_hi;
        corner_t mid_lo;
        corner_t mid_hi;
        corner_t tiny_lo;
        corner_t tiny_hi;
        all_min = {DIM{Q_MIN}};
        all_max = {DIM{Q_MAX}};
        // lane order in literals: w, z, y, x
        edge_lo = {-Q_ONE, 32'h0000_0001, 32'hFFFF_FFFF, Q_MIN};
        edge_hi = {Q_ONE, 32'h0012_3456, 32'h7FFF_0000, Q_MAX};
        mid_lo  = {32'h0000_8000, 32'hFFF0_0000, 32'h0003_0000, 32'hFFFF_C000};
        mid_hi  = {32'h0001_0000, 32'h0004_0000, 32'h0005_8000, 32'h0002_0000};
        tiny_lo = {32'h0000_0003, 32'hFFFF_FFFD, 32'hFFFF_FFFF, 32'h0000_0001};
        tiny_hi = {32'h0000_0007, 32'h0000_0005, 32'h0000_0002, 32'h0000_0003};

        // matrix is clear after reset
        directed_table[0]  = box_row(all_min, all_max, 1'b1, '0);
        directed_table[1]  = load_row(0, Q_ONE);
        directed_table[2]  = load_row(5, Q_ONE);
        directed_table[3]  = load_row(10, Q_ONE);
        directed_table[4]  = load_row(15, Q_ONE);
        // identity passes the box through
        directed_table[5]  = box_row(all_min, all_max, 1'b1, {all_max, all_min});
        directed_table[6]  = box_row(edge_lo, edge_hi, 1'b1, {edge_hi, edge_lo});
        directed_table[7]  = load_row(1, Q_MAX);
        directed_table[8]  = load_row(4, Q_MIN);
        directed_table[9]  = box_row(all_min, all_max, 1'b0, '0);
        directed_table[10] = box_row(mid_lo, mid_hi, 1'b0, '0);
        directed_table[11] = load_row(10, '0);
        directed_table[12] = load_row(15, '1);
        directed_table[13] = box_row(tiny_lo, tiny_hi, 1'b0, '0);
        directed_table[14] = load_row(3, -Q_ONE);
        directed_table[15] = load_row(12, 32'h0001_8000);
        directed_table[16] = box_row(mid_lo, mid_hi, 1'b0, '0);
        directed_table[17] = load_row(14, Q_MAX);
        directed_table[18] = load_row(11, Q_MAX);
        directed_table[19] = box_row(all_max, all_max, 1'b0, '0);
        directed_table[20] = box_row(mid_hi, mid_lo, 1'b0, '0);
        directed_table[21] = load_row(0, Q_MIN);
        directed_table[22] = box_row(all_min, all_min, 1'b0, '0);

        for (int e = 0; e < NUM_ENTRY; e++) coeff_store[e] = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        for (int v = 0; v < DIRECTED_ROWS; v++)
            send_request(directed_table[v].req, directed_table[v].typed, directed_table[v].want);

        for (int phase = 0; phase < 3; phase++) begin
            send_gap_pct   = (phase == 0) ? 20 : (phase == 1) ? 88 : 0;
            recv_stall_pct = (phase == 0) ? 88 : (phase == 1) ? 20 : 0;
            if (phase == 2) hold_go = 1'b1;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_request(random_request(), 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;

        while (expected_boxes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
